/* rtl/ipwr_pkg.sv */
// Shared types and constants for the IR pulse width recorder.
`default_nettype none
package ipwr_pkg;

  localparam int CAPTURE_DEPTH_DEF = 128;
  localparam int TIMER_WIDTH_DEF   = 16;
  localparam int READ_WIDTH_W      = 16;
  localparam int STORED_COUNT_W    = 8;
  localparam int READ_INDEX_W      = 7;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_EDGE = 2'd1,
    REQ_READ = 2'd2,
    REQ_ACK  = 2'd3
  } ipwr_kind_t;

  typedef struct packed {
    ipwr_kind_t                req_type;
    logic [READ_INDEX_W-1:0]   read_index;
  } ipwr_req_t;

  typedef struct packed {
    logic [READ_WIDTH_W-1:0]   read_width;
    logic [STORED_COUNT_W-1:0] stored_count;
    logic                      recording_done;
    logic                      overflow_seen;
    logic                      line_active;
    logic                      measuring;
  } ipwr_rsp_t;

  typedef struct packed {
    logic done;
    logic drop;
    logic polarity;
    logic running;
  } ipwr_status_t;

endpackage
`default_nettype wire

/* rtl/ipwr_store.sv */
// Capture memory: one write port, one registered read port.
`default_nettype none
module ipwr_store #(
  parameter int CAPTURE_DEPTH = 128,
  parameter int TIMER_WIDTH   = 16,
  localparam int AW = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [AW-1:0]          wr_addr,
  input  wire logic [TIMER_WIDTH-1:0] wr_data,
  input  wire logic                   rd_en,
  input  wire logic [AW-1:0]          rd_addr,
  output      logic [TIMER_WIDTH-1:0] rd_data
);

  logic [TIMER_WIDTH-1:0] mem [CAPTURE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/ipwr_ctrl.sv */
// Timer, polarity, count and mark updates with capture write generation.
`default_nettype none
module ipwr_ctrl #(
  parameter int CAPTURE_DEPTH = 128,
  parameter int TIMER_WIDTH   = 16,
  localparam int AW = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1,
  localparam int CW = $clog2(CAPTURE_DEPTH + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   accept,
  input  wire ipwr_pkg::ipwr_kind_t   kind,
  output      logic                   wr_en,
  output      logic [AW-1:0]          wr_addr,
  output      logic [TIMER_WIDTH-1:0] wr_data,
  output      logic [CW-1:0]          count,
  output      ipwr_pkg::ipwr_status_t status
);

  import ipwr_pkg::*;

  logic [TIMER_WIDTH-1:0] timer, timer_next;
  logic [CW-1:0]          count_next;
  ipwr_status_t           status_next;
  logic                   full;
  logic                   wrap;

  assign full    = (count >= CW'(CAPTURE_DEPTH));
  assign wrap    = (timer == '1);
  assign wr_addr = AW'(count);
  assign wr_data = timer;

  always_comb begin
    timer_next  = timer;
    count_next  = count;
    status_next = status;
    wr_en       = 1'b0;
    if (accept) begin
      unique case (kind)
        REQ_TICK: begin
          if (status.running) begin
            timer_next = timer + 1'b1;
            if (wrap && !status.polarity) begin
              status_next.done    = status.done | ~status.drop;
              status_next.drop    = 1'b0;
              status_next.running = 1'b0;
            end
          end
        end
        REQ_EDGE: begin
          status_next.polarity = ~status.polarity;
          status_next.running  = 1'b1;
          if (!status.running) begin
            count_next = '0;
          end else begin
            timer_next = '0;
            if (status.done || full) begin
              status_next.drop = 1'b1;
            end else begin
              wr_en      = 1'b1;
              count_next = count + 1'b1;
            end
          end
        end
        REQ_READ: begin
        end
        REQ_ACK: begin
          status_next.done = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer  <= '0;
      count  <= '0;
      status <= '0;
    end else begin
      timer  <= timer_next;
      count  <= count_next;
      status <= status_next;
    end
  end

  a_stopped_timer_zero: assert property (@(posedge clk) disable iff (rst)
    !status.running |-> timer == '0)
    else $error("timer nonzero while stopped");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPTURE_DEPTH))
    else $error("capture count beyond depth");

  a_drop_needs_run: assert property (@(posedge clk) disable iff (rst)
    status.drop |-> status.running)
    else $error("overflow mark set with timer stopped");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full && !status.done && status.running)
    else $error("capture write while full, done or stopped");

endmodule
`default_nettype wire

/* rtl/ir_pulse_width_recorder.sv */
// Top level of the IR pulse width recorder.
// Takes one item per clock when the result side keeps up; each result passes through the
// read stage register and then the output register (the capture memory read and the read
// stage register load at the edge that takes the item, the output register loads when the
// read stage advances). All recorder state except the capture buffer sits in flip-flops
// updated at the edge that takes the item; the buffer is a single memory written by edge
// items and read by read items. The buffer needs no clearing after reset: entries at or
// beyond the stored count read as zero. A full result register with a stalled consumer
// stalls the input side after one further item is held in the read stage.
`default_nettype none
module ir_pulse_width_recorder #(
  parameter int CAPTURE_DEPTH = ipwr_pkg::CAPTURE_DEPTH_DEF,
  parameter int TIMER_WIDTH   = ipwr_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output      logic                req_stall,
  input  wire ipwr_pkg::ipwr_req_t req,
  output      logic                rsp_valid,
  input  wire logic                rsp_stall,
  output      ipwr_pkg::ipwr_rsp_t rsp
);

  import ipwr_pkg::*;

  localparam int AW = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;
  localparam int CW = $clog2(CAPTURE_DEPTH + 1);
  localparam int XW = (CW > READ_INDEX_W) ? CW : READ_INDEX_W;

  logic                   accept;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [TIMER_WIDTH-1:0] wr_data;
  logic                   rd_en;
  logic [TIMER_WIDTH-1:0] rd_data;
  logic [CW-1:0]          count;
  ipwr_status_t           status;
  logic [XW-1:0]          idx_x;
  logic                   in_range;
  logic                   s1_valid;
  logic                   s1_hit;
  logic                   s1_adv;

  assign s1_adv    = !rsp_valid || !rsp_stall;
  assign req_stall = s1_valid && !s1_adv;
  assign accept    = req_valid && !req_stall;
  assign idx_x     = XW'(req.read_index);
  assign in_range  = (idx_x < XW'(count)) && (idx_x < XW'(CAPTURE_DEPTH));
  assign rd_en     = accept && (req.req_type == REQ_READ);

  ipwr_ctrl #(
    .CAPTURE_DEPTH (CAPTURE_DEPTH),
    .TIMER_WIDTH   (TIMER_WIDTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .kind    (req.req_type),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .count   (count),
    .status  (status)
  );

  ipwr_store #(
    .CAPTURE_DEPTH (CAPTURE_DEPTH),
    .TIMER_WIDTH   (TIMER_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (AW'(idx_x)),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (!req_stall) begin
        s1_valid <= accept;
      end
      if (s1_adv) begin
        rsp_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit <= rd_en && in_range;
    end
    if (s1_adv && s1_valid) begin
      rsp.read_width     <= s1_hit ? READ_WIDTH_W'(rd_data) : '0;
      rsp.stored_count   <= STORED_COUNT_W'(count);
      rsp.recording_done <= status.done;
      rsp.overflow_seen  <= status.drop;
      rsp.line_active    <= status.polarity;
      rsp.measuring      <= status.running;
    end
  end

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid && rsp_valid && rsp_stall)
    else $error("input stalled with free pipeline");

  a_held_stage_stays: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid)
    else $error("held read stage item lost");

  a_rsp_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

endmodule
`default_nettype wire
